// ----- hw/rtl/gyro_bias_still_calibrator_assert.svh -----
// assertion macros for the gyro bias calibrator
`ifndef GYRO_BIAS_STILL_CALIBRATOR_ASSERT_SVH
`define GYRO_BIAS_STILL_CALIBRATOR_ASSERT_SVH

// a condition implies a consequence in the same cycle
`define GBC_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// a condition implies a consequence in the next cycle
`define GBC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/gbc_pkg.sv -----
// ----------------------------------------------------------------------------
// gbc_pkg
// types, constants and status codes shared by the calibrator modules
// ----------------------------------------------------------------------------
package gbc_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_AXES        = 3;

	localparam logic [1:0] ST_PROGRESS  = 2'd0;
	localparam logic [1:0] ST_RESTARTED = 2'd1;
	localparam logic [1:0] ST_COMPLETE  = 2'd2;
	localparam logic [1:0] ST_INVALID   = 2'd3;

	localparam logic [2:0] REG_AXIS_MAP  = 3'd0;
	localparam logic [2:0] REG_GYRO_LIM  = 3'd1;
	localparam logic [2:0] REG_ACCEL_MIN = 3'd2;
	localparam logic [2:0] REG_ACCEL_MAX = 3'd3;
	localparam logic [2:0] REG_VAR_MAX   = 3'd4;
	localparam logic [2:0] REG_SAMPLES   = 3'd5;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
	} in_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        sample_count;
		logic signed [31:0] bias_x;
		logic signed [31:0] bias_y;
		logic signed [31:0] bias_z;
		logic signed [31:0] accel_total_x;
		logic signed [31:0] accel_total_y;
		logic signed [31:0] accel_total_z;
	} out_req_t;

	// control from the sequencer to the lanes
	typedef struct packed {
		logic start;     // begin division of delta by n
		logic commit;    // write back the accel sum
		logic clear;     // clear all calibration state
		logic vstart;    // begin variance division by n-1
	} lane_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -40'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ----- hw/rtl/gyro_bias_still_calibrator.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_still_calibrator
// still-period gyro bias estimation with per-axis welford variance
// ----------------------------------------------------------------------------
// flow: a still sample passes S_NORM, S_DIV and S_OUT, plus S_VAR (not at a
//   count of one) and S_VWAIT when it reaches the target; motion passes S_NORM
//   and S_OUT, an invalid map or a finished calibration only S_OUT; out_stall
//   holds S_OUT; one request in flight, set by the 48-step serial divider in each
//   lane; the next request is taken in the cycle after the result is loaded
// reset: arst_n clears all calibration state and loads the register defaults
module gyro_bias_still_calibrator #(
	parameter int COUNT_WIDTH = gbc_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = gbc_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gbc_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output gbc_pkg::out_req_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int NA = gbc_pkg::NUM_AXES;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	logic [8:0]  axis_map_q;
	logic [31:0] gyro_lim_q, amin_q, amax_q;
	logic [15:0] var_max_q, samples_q;

	gbc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.axis_map_q, .gyro_lim_q, .amin_q, .amax_q, .var_max_q, .samples_q
	);

	// sequencer
	typedef enum logic [2:0] {S_IDLE, S_NORM, S_DIV, S_VAR, S_VWAIT, S_OUT} state_t;
	state_t state_q;

	logic [COUNT_WIDTH-1:0] count_q, n_q;
	logic                   done_q;
	logic signed [16:0]     acc_s1 [NA];
	logic signed [16:0]     rate_s1 [NA];
	logic [34:0]            gn_s1, an_s1;
	logic signed [31:0]     bias_q [NA];
	gbc_pkg::lane_ctl_t     ctl;
	logic [NA-1:0]          busy, vbad;
	logic signed [31:0]     mean_sat [NA], sum_sat [NA];
	logic                   wait_q;
	logic [1:0]             status_q;   // status of the request in flight
	logic                   load_out;

	// axis map check: every source below three and all distinct
	logic [1:0] src [NA];
	logic       map_ok;
	always_comb begin
		for (int k = 0; k < NA; k++) src[k] = axis_map_q[3*k +: 2];
		map_ok = (src[0] != 2'd3) && (src[1] != 2'd3) && (src[2] != 2'd3) &&
			(src[0] != src[1]) && (src[0] != src[2]) && (src[1] != src[2]);
	end

	// remapped sample
	logic signed [16:0] acc_m [NA], rate_m [NA];
	logic signed [15:0] ain [NA], rin [NA];
	always_comb begin
		ain[0] = in_data.accel_x; ain[1] = in_data.accel_y; ain[2] = in_data.accel_z;
		rin[0] = in_data.rate_x;  rin[1] = in_data.rate_y;  rin[2] = in_data.rate_z;
		for (int k = 0; k < NA; k++) begin
			acc_m[k]  = 17'(ain[0]); rate_m[k] = 17'(rin[0]);
			case (src[k])
				2'd1: begin acc_m[k] = 17'(ain[1]); rate_m[k] = 17'(rin[1]); end
				2'd2: begin acc_m[k] = 17'(ain[2]); rate_m[k] = 17'(rin[2]); end
				default: ;
			endcase
			if (axis_map_q[3*k+2]) begin
				acc_m[k] = -acc_m[k]; rate_m[k] = -rate_m[k];
			end
		end
	end

	logic [COUNT_WIDTH-1:0] target, n_next;
	always_comb begin
		target = (samples_q == 16'd0) ? COUNT_WIDTH'(1) :
			((32'(samples_q) > 32'(CMAX)) ? CMAX : COUNT_WIDTH'(samples_q));
		n_next = (count_q == CMAX) ? CMAX : count_q + COUNT_WIDTH'(1);
	end

	logic still;
	assign still = (gn_s1 < 35'(gyro_lim_q)) && (an_s1 >= 35'(amin_q)) &&
		(an_s1 <= 35'(amax_q));

	logic [47:0] lim;
	assign lim = 48'(var_max_q) << FRAC_BITS;

	// a result waiting in the output register holds the sequencer at S_OUT, and
	// the input stays stalled until the sequencer is back in S_IDLE
	assign in_stall = (state_q != S_IDLE);
	assign load_out = (state_q == S_OUT) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; count_q <= '0; done_q <= 1'b0;
			ctl <= '0; wait_q <= 1'b0; n_q <= '0; status_q <= gbc_pkg::ST_PROGRESS;
			out_data <= '0; gn_s1 <= '0; an_s1 <= '0;
			for (int k = 0; k < NA; k++) begin
				bias_q[k] <= '0; acc_s1[k] <= '0; rate_s1[k] <= '0;
			end
		end else begin
			ctl <= '0;
			wait_q <= 1'b0;
			if (load_out) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					if (!map_ok) begin
						status_q <= gbc_pkg::ST_INVALID;
						state_q <= S_OUT;
					end else if (done_q) begin
						status_q <= gbc_pkg::ST_COMPLETE;
						state_q <= S_OUT;
					end else begin
						for (int k = 0; k < NA; k++) begin
							acc_s1[k] <= acc_m[k]; rate_s1[k] <= rate_m[k];
						end
						gn_s1 <= 35'(rate_m[0]*rate_m[0]) + 35'(rate_m[1]*rate_m[1]) +
							35'(rate_m[2]*rate_m[2]);
						an_s1 <= 35'(acc_m[0]*acc_m[0]) + 35'(acc_m[1]*acc_m[1]) +
							35'(acc_m[2]*acc_m[2]);
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!still) begin
						ctl.clear <= 1'b1; count_q <= '0; done_q <= 1'b0;
						for (int k = 0; k < NA; k++) bias_q[k] <= '0;
						status_q <= gbc_pkg::ST_RESTARTED;
						state_q <= S_OUT;
					end else begin
						n_q <= n_next;
						ctl.start <= 1'b1; ctl.commit <= 1'b1;
						wait_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: if (!wait_q && busy == '0) begin
					count_q <= n_q;
					if (n_q < target) begin
						status_q <= gbc_pkg::ST_PROGRESS;
						state_q <= S_OUT;
					end else if (n_q > COUNT_WIDTH'(1)) begin
						ctl.vstart <= 1'b1; wait_q <= 1'b1;
						state_q <= S_VAR;
					end else begin
						state_q <= S_VWAIT;
					end
				end
				S_VAR: if (!wait_q && busy == '0) state_q <= S_VWAIT;
				S_VWAIT: begin
					// the check flag is registered in the cycle after the divider ends
					if (n_q > COUNT_WIDTH'(1) && vbad != '0) begin
						ctl.clear <= 1'b1; count_q <= '0;
						status_q <= gbc_pkg::ST_RESTARTED;
					end else begin
						done_q <= 1'b1;
						for (int k = 0; k < NA; k++) bias_q[k] <= mean_sat[k];
						status_q <= gbc_pkg::ST_COMPLETE;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (load_out) begin
					// a lane clear lands at this edge unless the output stalled, so a restart reports zero sums
					out_data.status        <= status_q;
					out_data.sample_count  <= 16'(count_q);
					out_data.bias_x        <= bias_q[0];
					out_data.bias_y        <= bias_q[1];
					out_data.bias_z        <= bias_q[2];
					out_data.accel_total_x <= ctl.clear ? 32'sd0 : sum_sat[0];
					out_data.accel_total_y <= ctl.clear ? 32'sd0 : sum_sat[1];
					out_data.accel_total_z <= ctl.clear ? 32'sd0 : sum_sat[2];
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// three lanes run side by side, merged by the sequencer above
	for (genvar k = 0; k < NA; k++) begin : g_lane
		gbc_lane #(.COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk, .arst_n, .ctl, .rate(rate_s1[k]), .accel(acc_s1[k]), .n(n_q), .lim,
			.busy(busy[k]), .var_bad(vbad[k]), .mean_sat(mean_sat[k]),
			.sum_sat(sum_sat[k])
		);
	end

	`include "gyro_bias_still_calibrator_assert.svh"
	`GBC_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, in_stall, "busy accept")
	`GBC_ASSERT_NEXT(a_out_after_out, clk, arst_n, state_q == S_OUT, out_valid, "no result")
	`GBC_ASSERT_IMP(a_done_count, clk, arst_n, done_q && state_q == S_IDLE, count_q != '0, "zero count")
	`GBC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, $stable(out_data), "result moved")
endmodule

// ----- hw/rtl/gbc_lane.sv -----
// ----------------------------------------------------------------------------
// gbc_lane
// one axis: welford mean and m2 update, accel sum, variance check
// ----------------------------------------------------------------------------
module gbc_lane #(
	parameter int COUNT_WIDTH = gbc_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = gbc_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gbc_pkg::lane_ctl_t         ctl,
	input  logic signed [16:0]         rate,
	input  logic signed [16:0]         accel,
	input  logic [COUNT_WIDTH-1:0]     n,
	input  logic [47:0]                lim,
	output logic                       busy,
	output logic                       var_bad,
	output logic signed [31:0]         mean_sat,
	output logic signed [31:0]         sum_sat
);
	localparam int MW = 17 + FRAC_BITS + 1;   // mean / delta width
	localparam int DW = 48;                   // dividend width for shared divider
	localparam int SW = $clog2(DW + 1);

	logic signed [MW-1:0] mean_q;
	logic [47:0]          m2_q;
	logic signed [32:0]   sum_q;

	// restoring divider, one quotient bit per cycle
	logic [DW-1:0]          rem_q, quo_q;
	logic [COUNT_WIDTH-1:0] dvs_q;
	logic [SW-1:0]          cnt_q;
	logic                   run_q, neg_q, mode_q, done_q;

	logic signed [MW-1:0] x;
	logic signed [MW-1:0] d;
	logic [DW-1:0]        dmag;
	logic [DW:0]          trial;

	assign x = MW'(rate) <<< FRAC_BITS;
	assign d = x - mean_q;
	assign dmag = d[MW-1] ? DW'(-d) : DW'(d);
	assign trial = {rem_q, quo_q[DW-1]} - {{(DW+1-COUNT_WIDTH){1'b0}}, dvs_q};

	// post-division welford update
	logic signed [MW-1:0] q_s;
	logic signed [MW-1:0] mean_new;
	logic signed [MW-1:0] e;
	logic [MW-1:0]        dm, em;
	logic [2*MW-1:0]      prod_s2;
	logic                 opp_s2, mul_v_s2, mul_v_q;
	logic [47:0]          inc;
	logic [48:0]          m2_sum;

	// accel sum one bit wider, saturated back to 33 bits
	logic signed [33:0]   sum_ext;

	assign q_s      = neg_q ? -MW'(quo_q) : MW'(quo_q);
	assign mean_new = mean_q + q_s;
	assign e        = x - mean_new;
	assign dm       = d[MW-1] ? -d : d;
	assign em       = e[MW-1] ? -e : e;
	assign sum_ext  = 34'(sum_q) + 34'(accel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0; done_q <= 1'b0; mul_v_q <= 1'b0;
			mean_q <= '0; m2_q <= '0; sum_q <= '0; var_bad <= 1'b0;
			cnt_q <= '0; mode_q <= 1'b0; neg_q <= 1'b0; mul_v_s2 <= 1'b0;
			rem_q <= '0; quo_q <= '0; dvs_q <= '0; prod_s2 <= '0; opp_s2 <= 1'b0;
		end else begin
			done_q <= 1'b0;
			mul_v_s2 <= 1'b0;
			if (ctl.clear) begin
				mean_q <= '0; m2_q <= '0; sum_q <= '0;
				run_q <= 1'b0;
			end else if (ctl.start) begin
				run_q <= 1'b1; mode_q <= 1'b0; cnt_q <= SW'(DW);
				rem_q <= '0; quo_q <= dmag; dvs_q <= n; neg_q <= d[MW-1];
			end else if (ctl.vstart) begin
				run_q <= 1'b1; mode_q <= 1'b1; cnt_q <= SW'(DW);
				rem_q <= '0; quo_q <= m2_q; dvs_q <= n - COUNT_WIDTH'(1);
				var_bad <= 1'b0;
			end else if (run_q) begin
				if (!trial[DW]) begin
					rem_q <= trial[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - SW'(1);
				if (cnt_q == SW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q) begin
				if (mode_q) begin
					var_bad <= quo_q > lim;
				end else begin
					// register the product before the accumulate
					prod_s2  <= dm * em;
					opp_s2   <= (d[MW-1] != e[MW-1]) && (d != 0) && (e != 0);
					mean_q   <= mean_new;
					mul_v_s2 <= 1'b1;
				end
			end
			mul_v_q <= mul_v_s2;
			if (mul_v_s2 && !ctl.clear) begin
				m2_q <= m2_sum[48] ? 48'hffffffffffff : m2_sum[47:0];
			end
			if (ctl.commit && !ctl.clear) begin
				sum_q <= (sum_ext > 34'sh0ffffffff) ? 33'sh0ffffffff :
					((sum_ext < -34'sh100000000) ? 33'sh100000000 : sum_ext[32:0]);
			end
		end
	end

	logic [2*MW-1:0] sh;
	assign sh  = prod_s2 >> FRAC_BITS;
	assign inc = opp_s2 ? 48'd0 : ((|(sh >> 48)) ? 48'hffffffffffff : sh[47:0]);
	assign m2_sum = {1'b0, m2_q} + {1'b0, inc};

	assign busy     = run_q | done_q | mul_v_s2 | mul_v_q;
	assign mean_sat = gbc_pkg::sat32(40'(mean_q));
	assign sum_sat  = gbc_pkg::sat32(40'(sum_q));
endmodule

// ----- hw/rtl/gbc_regs.sv -----
// ----------------------------------------------------------------------------
// gbc_regs
// apb register file for the calibrator configuration
// ----------------------------------------------------------------------------
module gbc_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [8:0]  axis_map_q,
	output logic [31:0] gyro_lim_q,
	output logic [31:0] amin_q,
	output logic [31:0] amax_q,
	output logic [15:0] var_max_q,
	output logic [15:0] samples_q
);
	logic [2:0] idx;
	assign idx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_map_q <= 9'd136; gyro_lim_q <= 32'd9683;
			amin_q <= 32'd3030385; amax_q <= 32'd5546967;
			var_max_q <= 16'd67; samples_q <= 16'd200;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				gbc_pkg::REG_AXIS_MAP:  axis_map_q <= pwdata[8:0];
				gbc_pkg::REG_GYRO_LIM:  gyro_lim_q <= pwdata;
				gbc_pkg::REG_ACCEL_MIN: amin_q <= pwdata;
				gbc_pkg::REG_ACCEL_MAX: amax_q <= pwdata;
				gbc_pkg::REG_VAR_MAX:   var_max_q <= pwdata[15:0];
				gbc_pkg::REG_SAMPLES:   samples_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			gbc_pkg::REG_AXIS_MAP:  prdata = {23'd0, axis_map_q};
			gbc_pkg::REG_GYRO_LIM:  prdata = gyro_lim_q;
			gbc_pkg::REG_ACCEL_MIN: prdata = amin_q;
			gbc_pkg::REG_ACCEL_MAX: prdata = amax_q;
			gbc_pkg::REG_VAR_MAX:   prdata = {16'd0, var_max_q};
			gbc_pkg::REG_SAMPLES:   prdata = {16'd0, samples_q};
			default:                prdata = 32'd0;
		endcase
	end
endmodule

// ----- tb/gyro_bias_still_calibrator_check.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_still_calibrator_check
// watches the request channels and the register port, predicts every result
// of the calibrator with its own welford model and compares field by field
// ----------------------------------------------------------------------------
module gyro_bias_still_calibrator_check
	import gbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_req_t     in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_req_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          completions
);

	localparam longint unsigned M2_SAT  = (64'd1 << 48) - 1;
	localparam longint unsigned CNT_SAT = 65535;

	// register copy
	logic [8:0]  map_q;
	logic [31:0] glim_q, amin_q, amax_q;
	logic [15:0] vmax_q, need_q;

	// calibration state copy
	longint unsigned n_still;
	bit              cal_done;
	longint          mean_q [3];
	longint unsigned m2_q   [3];
	longint          asum_q [3];
	longint          bias_q [3];

	out_req_t results_due [$];

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic void wipe_cal();
		n_still  = 0;
		cal_done = 0;
		for (int k = 0; k < 3; k++) begin
			mean_q[k] = 0;
			m2_q[k]   = 0;
			asum_q[k] = 0;
			bias_q[k] = 0;
		end
	endfunction

	function automatic bit map_ok();
		logic [2:0] used;
		logic [1:0] src;
		used = 0;
		for (int k = 0; k < 3; k++) begin
			src = map_q[3*k +: 2];
			if (src > 2 || used[src])
				return 0;
			used[src] = 1;
		end
		return used == 3'b111;
	endfunction

	// one sample through the calibrator, returns the result it reports
	function automatic out_req_t calibrate(in_req_t s);
		out_req_t        r;
		logic [1:0]      st;
		longint          acc [3];
		longint          rt  [3];
		longint          ain [3];
		longint          rin [3];
		longint unsigned gn, an, n, tgt, inc, lim;
		longint          x, d, e;
		logic [127:0]    prod;
		logic [2:0]      g;
		bit              ok;
		ain = '{s.accel_x, s.accel_y, s.accel_z};
		rin = '{s.rate_x, s.rate_y, s.rate_z};
		if (!map_ok())
			st = ST_INVALID;
		else if (cal_done)
			st = ST_COMPLETE;
		else begin
			gn = 0;
			an = 0;
			for (int k = 0; k < 3; k++) begin
				g = map_q[3*k +: 3];
				acc[k] = g[2] ? -ain[g[1:0]] : ain[g[1:0]];
				rt[k]  = g[2] ? -rin[g[1:0]] : rin[g[1:0]];
				gn += rt[k] * rt[k];
				an += acc[k] * acc[k];
			end
			if (!(gn < glim_q && an >= amin_q && an <= amax_q)) begin
				wipe_cal();
				st = ST_RESTARTED;
			end else begin
				n   = n_still + 1;
				tgt = (need_q == 0) ? 1 : need_q;
				if (n > CNT_SAT)
					n = CNT_SAT;
				for (int k = 0; k < 3; k++) begin
					x = rt[k] <<< 16;
					d = x - mean_q[k];
					mean_q[k] += d / longint'(n);
					e = x - mean_q[k];
					if ((d < 0) != (e < 0) && d != 0 && e != 0)
						inc = 0;
					else begin
						prod = 128'((d < 0) ? -d : d) * 128'((e < 0) ? -e : e);
						inc  = prod[79:16];
					end
					if (inc >= M2_SAT - m2_q[k])
						m2_q[k] = M2_SAT;
					else
						m2_q[k] += inc;
					asum_q[k] += acc[k];
				end
				n_still = n;
				if (n < tgt)
					st = ST_PROGRESS;
				else begin
					ok = 1;
					if (n > 1) begin
						lim = longint'(vmax_q) << 16;
						for (int k = 0; k < 3; k++)
							if (m2_q[k] / (n - 1) > lim)
								ok = 0;
					end
					if (!ok) begin
						wipe_cal();
						st = ST_RESTARTED;
					end else begin
						for (int k = 0; k < 3; k++)
							bias_q[k] = mean_q[k];
						cal_done = 1;
						st = ST_COMPLETE;
					end
				end
			end
		end
		r.status        = st;
		r.sample_count  = n_still[15:0];
		r.bias_x        = clip32(bias_q[0]);
		r.bias_y        = clip32(bias_q[1]);
		r.bias_z        = clip32(bias_q[2]);
		r.accel_total_x = clip32(asum_q[0]);
		r.accel_total_y = clip32(asum_q[1]);
		r.accel_total_z = clip32(asum_q[2]);
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_req_t want;
		if (!arst_n) begin
			map_q  = 9'd136;
			glim_q = 32'd9683;
			amin_q = 32'd3030385;
			amax_q = 32'd5546967;
			vmax_q = 16'd67;
			need_q = 16'd200;
			wipe_cal();
			results_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_AXIS_MAP:  map_q  = pwdata[8:0];
					REG_GYRO_LIM:  glim_q = pwdata;
					REG_ACCEL_MIN: amin_q = pwdata;
					REG_ACCEL_MAX: amax_q = pwdata;
					REG_VAR_MAX:   vmax_q = pwdata[15:0];
					REG_SAMPLES:   need_q = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				results_due.push_back(calibrate(in_data));
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					want = results_due.pop_front();
					check_field("status", want.status, out_data.status);
					check_field("sample_count", want.sample_count, out_data.sample_count);
					check_field("bias_x", want.bias_x, out_data.bias_x);
					check_field("bias_y", want.bias_y, out_data.bias_y);
					check_field("bias_z", want.bias_z, out_data.bias_z);
					check_field("accel_total_x", want.accel_total_x, out_data.accel_total_x);
					check_field("accel_total_y", want.accel_total_y, out_data.accel_total_y);
					check_field("accel_total_z", want.accel_total_z, out_data.accel_total_z);
					checked++;
					if (out_data.status == ST_COMPLETE)
						completions++;
				end
			end
		end
		pending = results_due.size();
	end

	initial begin
		errors      = 0;
		pending     = 0;
		checked     = 0;
		completions = 0;
	end

endmodule

// ----- tb/gyro_bias_still_calibrator_test.sv -----
// ----------------------------------------------------------------------------
// gyro_bias_still_calibrator_test
// drives directed and random six-axis samples and register settings into the
// calibrator with random idling on both channels; a checker predicts results
// ----------------------------------------------------------------------------
module gyro_bias_still_calibrator_test;
	import gbc_pkg::*;

	localparam int SETTLE = 200;   // cycles after the last result before a write

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_req_t     in_data;
	logic        out_valid;
	logic        out_stall;
	out_req_t    out_data;
	logic        psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;

	int errors, pending, checked, completions;
	int sent;
	bit quiet;        // no idling on either side
	int hold_left;    // long receiver hold-off, counted in cycles

	gyro_bias_still_calibrator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gyro_bias_still_calibrator_check u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(errors), .pending(pending), .checked(checked),
		.completions(completions)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// hard stop well past the slowest legal run
	initial begin
		#40000000;
		$display("gyro_bias_still_calibrator_test: FAIL");
		$finish;
	end

	// receiver: random stall bursts, plus the long hold-off when asked
	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (burst > 0 && !quiet) begin
				out_stall <= 1'b1;
				burst--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(0, 9);
			end else begin
				out_stall <= 1'b0;
				burst = 0;
			end
		end
	end

	// one request, held until accepted, then maybe a gap
	task automatic send(in_req_t s);
		int gap;
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap)
				@(negedge clk);
		end
	endtask

	// register write: setup then access, only with the block idle
	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// wait out every outstanding result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE)
			@(negedge clk);
	endtask

	// a plausible resting sample: about 1 g on z, small rates
	function automatic in_req_t still_sample();
		in_req_t s;
		s.accel_x = 16'($signed($urandom_range(0, 400)) - 200);
		s.accel_y = 16'($signed($urandom_range(0, 400)) - 200);
		s.accel_z = 16'($signed($urandom_range(0, 200)) + 1948);
		s.rate_x  = 16'($signed($urandom_range(0, 60)) - 30);
		s.rate_y  = 16'($signed($urandom_range(0, 60)) - 30);
		s.rate_z  = 16'($signed($urandom_range(0, 60)) - 30);
		if ($urandom_range(0, 1))
			s.accel_z = -s.accel_z;
		return s;
	endfunction

	function automatic in_req_t noise_sample();
		return in_req_t'({$urandom, $urandom, $urandom});
	endfunction

	// a random valid permutation with random signs
	function automatic logic [8:0] pick_map();
		logic [1:0] p [3];
		int j;
		logic [1:0] t;
		p = '{2'd0, 2'd1, 2'd2};
		for (int k = 2; k > 0; k--) begin
			j    = $urandom_range(0, k);
			t    = p[k];
			p[k] = p[j];
			p[j] = t;
		end
		return {1'($urandom), p[2], 1'($urandom), p[1], 1'($urandom), p[0]};
	endfunction

	initial begin
		in_req_t s;
		int      n_items;
		logic [31:0] amin, amax;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		quiet     = 1'b0;
		hold_left = 0;
		sent      = 0;
		repeat (10)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: defaults, still samples, motion, field extremes
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0}));
		send(in_req_t'({16'sd10, -16'sd5, 16'sd2040, 16'sd3, -16'sd2, 16'sd1}));
		send(in_req_t'({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}));
		send(in_req_t'({6{16'sh7fff}}));
		send(in_req_t'({6{16'sh8000}}));
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, 16'sd56, 16'sd0, 16'sd0}));
		send(in_req_t'({16'sd0, 16'sd0, -16'sd2048, 16'sd0, 16'sd0, -16'sd30}));
		drain();

		// invalid maps: source above z, then duplicated sources
		reg_write(REG_AXIS_MAP, 32'h1ff);
		send(in_req_t'({6{16'sh8000}}));
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0}));
		drain();
		reg_write(REG_AXIS_MAP, 32'h000);
		send(in_req_t'({6{16'sh7fff}}));
		drain();
		// another invalid map: x from y, y from z, z negated from a source above z
		reg_write(REG_AXIS_MAP, 32'h1d1);
		send(in_req_t'({16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0}));
		send(in_req_t'({16'sd2048, 16'sd0, 16'sd0, -16'sd20, 16'sd10, 16'sd5}));
		send(in_req_t'({16'sd100, 16'sd2000, -16'sd50, 16'sd0, 16'sd40, -16'sd8}));
		drain();
		// short target with zero variance allowed: noisy rates restart it
		reg_write(REG_AXIS_MAP, 32'd136);
		reg_write(REG_VAR_MAX, 32'd0);
		reg_write(REG_SAMPLES, 32'd3);
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, 16'sd20, 16'sd0, 16'sd0}));
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, -16'sd20, 16'sd0, 16'sd0}));
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, 16'sd20, 16'sd0, 16'sd0}));
		drain();
		// empty accel band and a zero gyro limit: nothing is still
		reg_write(REG_ACCEL_MIN, 32'hffffffff);
		reg_write(REG_ACCEL_MAX, 32'd0);
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0}));
		drain();
		reg_write(REG_ACCEL_MIN, 32'd0);
		reg_write(REG_ACCEL_MAX, 32'hffffffff);
		reg_write(REG_GYRO_LIM, 32'd0);
		send(in_req_t'({16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'sd0}));
		drain();

		// random phases: mostly resting runs, some motion and raw noise;
		// variance limit kept tiny so a reached target restarts
		for (int ph = 0; ph < 20; ph++) begin
			reg_write(REG_AXIS_MAP, ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 511))
				: 32'(pick_map()));
			case ($urandom_range(0, 5))
				0: reg_write(REG_GYRO_LIM, 32'hffffffff);
				1: reg_write(REG_GYRO_LIM, 32'd1);
				default: reg_write(REG_GYRO_LIM, 32'd9683);
			endcase
			amin = 32'd3030385;
			amax = 32'd5546967;
			case ($urandom_range(0, 7))
				0: begin amin = 32'd0; amax = 32'hffffffff; end
				1: begin amin = 32'd5546967; amax = 32'd3030385; end
				default: ;
			endcase
			reg_write(REG_ACCEL_MIN, amin);
			reg_write(REG_ACCEL_MAX, amax);
			reg_write(REG_VAR_MAX, 32'($urandom_range(0, 2)));
			reg_write(REG_SAMPLES, ($urandom_range(0, 7) == 0) ? 32'd65535
				: 32'($urandom_range(4, 40)));
			if (ph == 5)
				hold_left = 400;   // block fills up while requests keep coming
			n_items = $urandom_range(70, 90);
			for (int i = 0; i < n_items; i++) begin
				case ($urandom_range(0, 19))
					0: s = noise_sample();
					1: begin
						s = still_sample();
						s.rate_y = 16'($signed($urandom_range(0, 2000)) - 1000);
					end
					default: s = still_sample();
				endcase
				send(s);
			end
			drain();
		end

		// last part, no idling: wide variance and a target of zero completes
		quiet = 1'b1;
		reg_write(REG_AXIS_MAP, 32'd136);
		reg_write(REG_GYRO_LIM, 32'd9683);
		reg_write(REG_ACCEL_MIN, 32'd3030385);
		reg_write(REG_ACCEL_MAX, 32'd5546967);
		reg_write(REG_VAR_MAX, 32'd65535);
		reg_write(REG_SAMPLES, 32'd0);
		for (int i = 0; i < 30; i++)
			send((i % 3 == 2) ? noise_sample() : still_sample());
		drain();
		// a bad map still wins over a finished calibration
		reg_write(REG_AXIS_MAP, 32'h0c0);
		for (int i = 0; i < 5; i++)
			send(noise_sample());
		drain();

		$display("covered %0d samples, %0d results checked, %0d complete reports",
			sent, checked, completions);
		$display("register sweeps over axis maps, stillness limits, variance and targets");
		if (errors == 0)
			$display("gyro_bias_still_calibrator_test: PASS");
		else
			$display("gyro_bias_still_calibrator_test: FAIL");
		$finish;
	end

endmodule
